// ===== hw/rtl/pia_pkg.sv =====
// Shared types and constants for the packet identifier allocator.
`timescale 1ns / 1ps

package pia_pkg;

  // Bitmap organization: one memory word covers this many identifiers.
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned BIT_IDX_W = 5;

  // Result status codes.
  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_EXHAUSTED = 2'd1,
    STAT_UNALLOC   = 2'd2,
    STAT_ZERO      = 2'd3
  } status_e;

  // Command codes.
  typedef enum logic {
    CMD_ALLOC   = 1'b0,
    CMD_RELEASE = 1'b1
  } cmd_e;

endpackage

// ===== hw/rtl/pia_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module pia_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/packet_id_allocator_top.sv =====
// Top level of the packet identifier allocator: bitmap memory, scan sequencer, result register.
`timescale 1ns / 1ps
// An accepted request is held while its bitmap word is read and then evaluated; the result
//   goes to the result register. An allocate reads one further 32-identifier bitmap word for
//   every word it has to scan past (one read/cycle). The input is stalled until the sequencer is
//   idle again; a stalled result word holds the sequencer and with it the input.
// Reset: control state clears at once, then a clearing pass writes zero to every bitmap word,
//   2^max(ID_BITS-5, 1) words (2048 at ID_BITS = 16); input is stalled meanwhile.

module packet_id_allocator_top
  import pia_pkg::*;
#(
  parameter int unsigned ID_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  // request channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [15:0] release_id_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] granted_id_o,
  output logic [1:0]  status_o
);

  // Word address width of the bitmap; at least one bit so the RAM is well formed.
  localparam int unsigned WA    = (ID_BITS > BIT_IDX_W) ? (ID_BITS - BIT_IDX_W) : 1;
  localparam int unsigned DEPTH = 2 ** WA;
  // Identifier width once split into word address and bit index.
  localparam int unsigned IDW   = WA + BIT_IDX_W;

  // Sequencer states.
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_EVAL  = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [WA-1:0]        clr_q, clr_d;
  logic [15:0]          max_q;
  logic [ID_BITS-1:0]   count_q, count_d;
  logic [ID_BITS-1:0]   last_q, last_d;

  // Request held while its word is fetched and evaluated.
  logic                 cmd_q, cmd_d;
  logic                 quick_q, quick_d;
  status_e              qstat_q, qstat_d;
  logic [WA-1:0]        word_q, word_d;
  logic [BIT_IDX_W-1:0] bit_q, bit_d;
  logic                 first_q, first_d;

  // Result register.
  logic                 out_valid_q, out_valid_d;
  logic [15:0]          granted_q, granted_d;
  status_e              status_q, status_d;

  // Memory ports.
  logic                 ram_we, ram_re;
  logic [WA-1:0]        ram_waddr, ram_raddr;
  logic [WORD_BITS-1:0] ram_wdata, ram_rdata;

  pia_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (DEPTH)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // --------------------------------------------------------------------------
  // Request decode at the input
  // --------------------------------------------------------------------------
  logic               in_acc;
  logic               out_free;
  logic               exhausted;
  logic               rel_oor;
  logic [ID_BITS-1:0] rid;
  logic [ID_BITS-1:0] start_id;
  logic [ID_BITS-1:0] tgt_id;
  logic [IDW-1:0]     tgt_ext;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  // The result register can take a new word when empty or being drained this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;

  assign exhausted  = (16'(count_q) >= max_q) || (&count_q);
  assign rel_oor    = ((release_id_i >> ID_BITS) != 16'd0);
  assign rid        = release_id_i[ID_BITS-1:0];

  always_comb begin
    // Search starts one past the last grant, skipping zero on wrap.
    start_id = last_q + 1'b1;
    if (start_id == '0) begin
      start_id = ID_BITS'(1);
    end
  end

  assign tgt_id  = (cmd_i == CMD_RELEASE) ? rid : start_id;
  assign tgt_ext = IDW'(tgt_id);

  // --------------------------------------------------------------------------
  // Word evaluation: find the lowest free identifier in the fetched word
  // --------------------------------------------------------------------------
  logic [WORD_BITS-1:0] free_vec;
  logic [BIT_IDX_W-1:0] free_pos;
  logic                 found;
  logic [IDW-1:0]       cand_ext;
  logic [IDW-1:0]       grant_ext;
  logic                 rel_hit;

  always_comb begin
    for (int i = 0; i < WORD_BITS; i++) begin
      cand_ext    = {word_q, BIT_IDX_W'(i)};
      // A bit is a candidate if it names a nonzero identifier inside the space,
      // is not below the start bit on the first word, and is clear in the bitmap.
      free_vec[i] = ((cand_ext >> ID_BITS) == '0) && (cand_ext != '0)
                    && (!first_q || (BIT_IDX_W'(i) >= bit_q))
                    && !ram_rdata[i];
    end
    free_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        free_pos = BIT_IDX_W'(i);
      end
    end
  end

  assign found     = |free_vec;
  assign grant_ext = {word_q, free_pos};
  assign rel_hit   = ram_rdata[bit_q];

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    count_d     = count_q;
    last_d      = last_q;
    cmd_d       = cmd_q;
    quick_d     = quick_q;
    qstat_d     = qstat_q;
    word_d      = word_q;
    bit_d       = bit_q;
    first_d     = first_q;
    granted_d   = granted_q;
    status_d    = status_q;
    out_valid_d = out_valid_q && out_stall_i;

    ram_we      = 1'b0;
    ram_waddr   = word_q;
    ram_wdata   = ram_rdata;
    ram_re      = 1'b0;
    ram_raddr   = word_q;

    unique case (state_q)
      ST_CLEAR: begin
        // Sweep the bitmap to zero after reset.
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (&clr_q) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_acc) begin
          cmd_d   = cmd_i;
          word_d  = tgt_ext[IDW-1:BIT_IDX_W];
          bit_d   = tgt_ext[BIT_IDX_W-1:0];
          first_d = 1'b1;
          // Outcomes that need no bitmap lookup.
          if (cmd_i == CMD_ALLOC) begin
            quick_d = exhausted;
            qstat_d = STAT_EXHAUSTED;
          end else begin
            quick_d = (release_id_i == 16'd0) || rel_oor;
            qstat_d = (release_id_i == 16'd0) ? STAT_ZERO : STAT_UNALLOC;
          end
          ram_re    = 1'b1;
          ram_raddr = tgt_ext[IDW-1:BIT_IDX_W];
          state_d   = ST_EVAL;
        end
      end

      ST_EVAL: begin
        priority if (quick_q) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            granted_d   = 16'd0;
            status_d    = qstat_q;
            state_d     = ST_IDLE;
          end
        end else if (cmd_q == CMD_RELEASE) begin
          if (out_free) begin
            out_valid_d = 1'b1;
            granted_d   = 16'd0;
            if (rel_hit) begin
              // Drop the identifier from the bitmap.
              ram_we    = 1'b1;
              ram_wdata = ram_rdata & ~(WORD_BITS'(1) << bit_q);
              if (count_q != '0) begin
                count_d = count_q - 1'b1;
              end
              status_d = STAT_OK;
            end else begin
              status_d = STAT_UNALLOC;
            end
            state_d = ST_IDLE;
          end else begin
            // Hold: refetch the same word until the result register frees up.
            ram_re = 1'b1;
          end
        end else if (found) begin
          if (out_free) begin
            ram_we      = 1'b1;
            ram_wdata   = ram_rdata | (WORD_BITS'(1) << free_pos);
            count_d     = count_q + 1'b1;
            last_d      = grant_ext[ID_BITS-1:0];
            out_valid_d = 1'b1;
            granted_d   = 16'(grant_ext[ID_BITS-1:0]);
            status_d    = STAT_OK;
            state_d     = ST_IDLE;
          end else begin
            ram_re = 1'b1;
          end
        end else begin
          // Advance to the next word, wrapping at the end of the bitmap.
          word_d    = word_q + 1'b1;
          first_d   = 1'b0;
          ram_re    = 1'b1;
          ram_raddr = word_q + 1'b1;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      max_q       <= 16'hFFFF;
      count_q     <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      count_q     <= count_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk_i) begin
    cmd_q     <= cmd_d;
    quick_q   <= quick_d;
    qstat_q   <= qstat_d;
    word_q    <= word_d;
    bit_q     <= bit_d;
    first_q   <= first_d;
    granted_q <= granted_d;
    status_q  <= status_d;
  end

  assign out_valid_o  = out_valid_q;
  assign granted_id_o = granted_q;
  assign status_o     = status_q;

endmodule

// ===== hw/rtl/pia_checker.sv =====
// Port-level checker for the packet identifier allocator, bound to the top level.
`timescale 1ns / 1ps

module pia_checker
  import pia_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] granted_id_o,
  input logic [1:0]  status_o
);

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_id_o) && $stable(status_o))
    else $error("stalled result word changed");

  // Any failure status comes with a zero identifier.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != STAT_OK) |-> granted_id_o == 16'd0)
    else $error("nonzero identifier with failure status");

  // One request in flight: an accepted word stalls the input next cycle.
  a_one_inflight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accept");

  // The clearing pass stalls the input right after reset.
  a_clear_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> in_stall_o)
    else $error("input open during bitmap clear");

endmodule

bind packet_id_allocator_top pia_checker u_pia_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .granted_id_o (granted_id_o),
  .status_o     (status_o)
);
